// ===== rtl/hltr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hltr_pkg
// shared widths, constants and types of the hue/lightness to rgb pipeline
// ----------------------------------------------------------------------------
package hltr_pkg;

  // payload widths
  localparam int HUE_W   = 16;
  localparam int LIGHT_W = 13;
  localparam int COLOR_W = 8;

  // hue scale: round(3/pi * 2^24), sixths of a turn
  localparam int HUE_K_W     = 24;
  localparam int HUE_K_SHIFT = 24;
  localparam logic [HUE_K_W-1:0] HUE_K = 24'd16021061;

  // integer sixths: 3 for the pi offset plus 384, a multiple of six
  localparam int SECT_IP_W = 10;
  localparam logic [SECT_IP_W-1:0] SIXTHS_BIAS = 10'd387;
  localparam logic [SECT_IP_W-1:0] SECTORS     = 10'd6;

  // reciprocal of six for the sector reduction (underestimate, one correction)
  localparam int RECIP6_W     = 8;
  localparam int RECIP6_SHIFT = 10;
  localparam logic [RECIP6_W-1:0] RECIP6 = 8'd170;

  // register stages from input to output register
  localparam int NUM_STAGES = 5;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef enum logic [1:0] {
    LM_DARK   = 2'd0,
    LM_BRIGHT = 2'd1,
    LM_BLACK  = 2'd2
  } light_mode_t;

endpackage

// ===== rtl/hltr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hltr_in_if
// input channel: hue and lightness with valid/ready
// ----------------------------------------------------------------------------
interface hltr_in_if import hltr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [HUE_W-1:0]   hue;
  logic        [LIGHT_W-1:0] lightness;

  modport source (output valid, hue, lightness, input ready);
  modport sink   (input valid, hue, lightness, output ready);
endinterface

// ===== rtl/hltr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hltr_out_if
// output channel: red, green and blue with valid/ready
// ----------------------------------------------------------------------------
interface hltr_out_if import hltr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hltr_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hltr_sector
// stages 1-3: hue scaling, sector and fraction, channel levels, lightness mode
// ----------------------------------------------------------------------------
module hltr_sector import hltr_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic [2:0]         adv,
  input  logic signed [HUE_W-1:0] hue,
  input  logic [LIGHT_W-1:0] lightness,
  output logic [FRAC_BITS:0] red_level,
  output logic [FRAC_BITS:0] green_level,
  output logic [FRAC_BITS:0] blue_level,
  output light_mode_t        mode,
  output logic [FRAC_BITS:0] light_mult
);

  localparam int PROD_W = HUE_K_SHIFT + FRAC_BITS + SECT_IP_W + 1;
  localparam int LW     = (LIGHT_W > FRAC_BITS + 1) ? LIGHT_W : FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 1
  logic signed [PROD_W-1:0] prod1;
  logic [LIGHT_W-1:0]       light1;

  // stage 2
  logic [SECT_IP_W-1:0]          sixths;
  logic [SECT_IP_W+RECIP6_W-1:0] quot_full;
  logic [RECIP6_W-1:0]           quot;
  logic [SECT_IP_W-1:0]          rem_full;
  logic [3:0]                    rem;
  logic [2:0]                    sector_raw;
  logic [LW:0]                   two_l;
  logic [LW:0]                   light_x;
  logic [LW:0]                   one_x;
  light_mode_t                   mode_next;
  logic [LW:0]                   mult_wide;
  sector_t                       sector2;
  logic [FRAC_BITS-1:0]          frac2;
  light_mode_t                   mode2;
  logic [FRAC_BITS:0]            mult2;

  // stage 3
  logic [FRAC_BITS:0] rise;
  logic [FRAC_BITS:0] fall;
  logic [FRAC_BITS:0] red_next;
  logic [FRAC_BITS:0] green_next;
  logic [FRAC_BITS:0] blue_next;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod1  <= PROD_W'(hue) * PROD_W'($signed({1'b0, HUE_K}));
      light1 <= lightness;
    end
  end

  // integer part in sixths, reduced mod 6 through a reciprocal multiply
  always_comb begin
    sixths     = prod1[HUE_K_SHIFT+FRAC_BITS +: SECT_IP_W] + SIXTHS_BIAS;
    quot_full  = (SECT_IP_W+RECIP6_W)'(sixths) * (SECT_IP_W+RECIP6_W)'(RECIP6);
    quot       = quot_full[RECIP6_SHIFT +: RECIP6_W];
    rem_full   = sixths - SECT_IP_W'(SECT_IP_W'(quot) * SECTORS);
    rem        = rem_full[3:0];
    if (rem >= 4'(SECTORS)) begin
      sector_raw = 3'(rem - 4'(SECTORS));
    end else begin
      sector_raw = rem[2:0];
    end
  end

  // lightness: scale below one half, blend toward white up to one, else black
  always_comb begin
    light_x = (LW+1)'(light1);
    two_l   = {light_x[LW-1:0], 1'b0};
    one_x   = (LW+1)'(ONE);
    if (two_l <= one_x) begin
      mode_next = LM_DARK;
      mult_wide = two_l;
    end else if (light_x <= one_x) begin
      mode_next = LM_BRIGHT;
      mult_wide = two_l - one_x;
    end else begin
      mode_next = LM_BLACK;
      mult_wide = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sector2 <= sector_t'(sector_raw);
      frac2   <= prod1[HUE_K_SHIFT +: FRAC_BITS];
      mode2   <= mode_next;
      mult2   <= mult_wide[FRAC_BITS:0];
    end
  end

  always_comb begin
    rise = (FRAC_BITS+1)'(frac2);
    fall = ONE - rise;
    case (sector2)
      SECTOR_0: begin
        red_next = '0;   green_next = fall; blue_next = ONE;
      end
      SECTOR_1: begin
        red_next = rise; green_next = '0;   blue_next = ONE;
      end
      SECTOR_2: begin
        red_next = ONE;  green_next = '0;   blue_next = fall;
      end
      SECTOR_3: begin
        red_next = ONE;  green_next = rise; blue_next = '0;
      end
      SECTOR_4: begin
        red_next = fall; green_next = ONE;  blue_next = '0;
      end
      SECTOR_5: begin
        red_next = '0;   green_next = ONE;  blue_next = rise;
      end
      default: begin
        red_next = '0;   green_next = '0;   blue_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      red_level   <= red_next;
      green_level <= green_next;
      blue_level  <= blue_next;
      mode        <= mode2;
      light_mult  <= mult2;
    end
  end

endmodule

// ===== rtl/hltr_shade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hltr_shade
// stages 4-5 of one channel: lightness product, blend and scale to 8 bits
// ----------------------------------------------------------------------------
module hltr_shade import hltr_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic [1:0]         adv,
  input  logic [FRAC_BITS:0] level,
  input  light_mode_t        mode,
  input  logic [FRAC_BITS:0] light_mult,
  output logic [COLOR_W-1:0] color
);

  localparam int V_W = 2 * FRAC_BITS + 1;
  localparam int S_W = V_W + COLOR_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0] mul_a;
  logic [V_W-1:0]     base_next;
  logic [V_W:0]       prod4;
  logic [V_W-1:0]     base4;
  logic [V_W:0]       sum;
  logic [V_W-1:0]     val;
  logic [S_W-1:0]     scaled;

  // dark: c*2L; bright: c*ONE + (ONE-c)*(2L-ONE); black: zero
  always_comb begin
    case (mode)
      LM_DARK: begin
        mul_a     = level;
        base_next = '0;
      end
      LM_BRIGHT: begin
        mul_a     = ONE - level;
        base_next = {level, {FRAC_BITS{1'b0}}};
      end
      default: begin
        mul_a     = '0;
        base_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod4 <= (V_W+1)'(mul_a) * (V_W+1)'(light_mult);
      base4 <= base_next;
    end
  end

  // times 255 as a shift and subtract, one truncation at the end
  always_comb begin
    sum    = prod4 + (V_W+1)'(base4);
    val    = sum[V_W-1:0];
    scaled = {val, {COLOR_W{1'b0}}} - S_W'(val);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      color <= scaled[2*FRAC_BITS +: COLOR_W];
    end
  end

endmodule

// ===== rtl/hue_lightness_to_rgb_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_lightness_to_rgb_unit
// full-saturation hue/lightness to 8-bit rgb, five-stage pipeline
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  pix_in    in   valid / ready  hue (s16, Q3.F radians), lightness (u13, Q.F)
//  pix_out   out  valid / ready  red, green, blue (u8 each)
//
//  one transaction in and one out per cycle while pix_out is not stalled
//  the five register stages are hue multiply, sector and lightness mode,
//    channel levels, lightness multiply, blend and scale
//  rst (synchronous) clears only the stage valid bits; data needs no reset
//  each stage holds when its successor is full and stalled, so bubbles
//    close up and a stalled output does not block a partly empty pipeline
//
module hue_lightness_to_rgb_unit import hltr_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  hltr_in_if.sink       pix_in,
  hltr_out_if.source    pix_out
);

  // stage valid bits, index 1 is the first register stage
  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:0] vld_src;
  // stage load enables
  logic [NUM_STAGES:1] adv;

  logic [FRAC_BITS:0] red_level;
  logic [FRAC_BITS:0] green_level;
  logic [FRAC_BITS:0] blue_level;
  light_mode_t        mode;
  logic [FRAC_BITS:0] light_mult;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NUM_STAGES] = !vld[NUM_STAGES] || pix_out.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vld_src      = {vld, pix_in.valid};
  assign pix_in.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k-1];
        end
      end
    end
  end

  // stages 1-3: sector, fraction and per-channel levels
  hltr_sector #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sector (
    .clk         (clk),
    .adv         (adv[3:1]),
    .hue         (pix_in.hue),
    .lightness   (pix_in.lightness),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .mode        (mode),
    .light_mult  (light_mult)
  );

  // stages 4-5: one shading lane per channel
  hltr_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade_red (
    .clk        (clk),
    .adv        (adv[5:4]),
    .level      (red_level),
    .mode       (mode),
    .light_mult (light_mult),
    .color      (pix_out.red)
  );

  hltr_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade_green (
    .clk        (clk),
    .adv        (adv[5:4]),
    .level      (green_level),
    .mode       (mode),
    .light_mult (light_mult),
    .color      (pix_out.green)
  );

  hltr_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade_blue (
    .clk        (clk),
    .adv        (adv[5:4]),
    .level      (blue_level),
    .mode       (mode),
    .light_mult (light_mult),
    .color      (pix_out.blue)
  );

  assign pix_out.valid = vld[NUM_STAGES];

  // input back-pressure only when every stage holds a transaction
  a_full_when_blocked : assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (&vld))
    else $error("input blocked with an empty stage");

  // a valid stage whose successor cannot load keeps its transaction
  a_mid_stage_holds : assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !adv[4]) |=> vld[3])
    else $error("stage 3 transaction lost during stall");

  // a loading stage takes the valid bit of its predecessor
  a_valid_moves : assert property (@(posedge clk) disable iff (rst)
    adv[2] |=> (vld[2] == $past(vld[1])))
    else $error("stage 2 valid bit out of step");

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule
